>>> src/pfs_pkg.sv
package pfs_pkg;

  localparam int ITEMS_MAX = 256;
  localparam int QUALITY_LEVELS = 16;
  localparam int ITEM_W = $clog2(ITEMS_MAX);
  localparam int CNT_W = ITEM_W + 1;
  localparam int QUAL_W = $clog2(QUALITY_LEVELS);
  localparam int LVL_W = QUAL_W + 1;
  localparam int BLK_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITEMS_COUNT = 2'd0,
    CFG_MAX_QUALITY = 2'd1,
    CFG_BLOCK_SIZE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_FETCH     = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic    cap;
    logic    set_focus;
    logic    rd_head;
    logic    setup;
    logic    pass_exhaust;
    logic    pass_next;
    logic    level_next;
    logic    rd_cand;
    logic    wr_head;
    logic    wr_cand;
    logic    emit;
    status_e emit_status;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic req_oob;
    logic focus_oob;
    logic head_pending;
    logic head_ok;
    logic pass_over;
    logic start_ge_n;
    logic level_over;
    logic pos_end;
    logic cand_ok;
  } sts_t;

  function automatic logic [ITEM_W-1:0] item_at(input logic [CNT_W-1:0] p,
                                                 input logic [ITEM_W-1:0] f,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W:0] below;
    logic [CNT_W:0] above;
    logic [CNT_W:0] m;
    logic [CNT_W:0] two_m;
    logic [CNT_W:0] pw;
    logic [CNT_W:0] k;
    logic [CNT_W:0] r;
    logic [CNT_W:0] res;
    below = {2'b00, f};
    above = {1'b0, n} - (CNT_W+1)'(1) - below;
    m = (below < above) ? below : above;
    two_m = {m[CNT_W-1:0], 1'b0};
    pw = {1'b0, p};
    k = (pw + (CNT_W+1)'(1)) >> 1;
    r = pw - two_m - (CNT_W+1)'(1);
    if (pw == '0) begin
      res = below;
    end else if (pw <= two_m) begin
      res = pw[0] ? below + k : below - k;
    end else if (below > above) begin
      res = below - m - (CNT_W+1)'(1) - r;
    end else begin
      res = below + m + (CNT_W+1)'(1) + r;
    end
    return res[ITEM_W-1:0];
  endfunction

endpackage

>>> src/pfs_ram.sv
module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pfs_ctrl.sv
module pfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pfs_pkg::sts_t sts_i,
  output pfs_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HEAD_CHK,
    S_SETUP,
    S_SCAN,
    S_CAND_CHK
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.emit_status = ST_FETCH;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        if (sts_i.mode) begin
          if (sts_i.req_oob) begin
            cmd_o.emit = 1'b1;
            cmd_o.emit_status = ST_RANGE;
          end else begin
            cmd_o.set_focus = 1'b1;
          end
        end else if (sts_i.focus_oob) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_status = ST_EXHAUSTED;
        end else if (sts_i.head_pending) begin
          cmd_o.rd_head = 1'b1;
          state_d = S_HEAD_CHK;
        end else begin
          state_d = S_SETUP;
        end
      end
      S_HEAD_CHK: begin
        if (sts_i.head_ok) begin
          cmd_o.wr_head = 1'b1;
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sts_i.pass_over) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_status = ST_EXHAUSTED;
          state_d = S_IDLE;
        end else if (sts_i.start_ge_n) begin
          cmd_o.pass_exhaust = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.emit_status = ST_EXHAUSTED;
          state_d = S_IDLE;
        end else begin
          cmd_o.setup = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.level_over) begin
          cmd_o.pass_next = 1'b1;
          state_d = S_SETUP;
        end else if (sts_i.pos_end) begin
          cmd_o.level_next = 1'b1;
        end else begin
          cmd_o.rd_cand = 1'b1;
          state_d = S_CAND_CHK;
        end
      end
      S_CAND_CHK: begin
        if (sts_i.cand_ok) begin
          cmd_o.wr_cand = 1'b1;
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

>>> src/pfs_dp.sv
module pfs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          mode_i,
  input  logic [pfs_pkg::ITEM_W-1:0]    focus_item_i,
  input  pfs_pkg::cmd_t                 cmd_i,
  output pfs_pkg::sts_t                 sts_o,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [pfs_pkg::ITEM_W-1:0]    item_o,
  output logic [pfs_pkg::QUAL_W-1:0]    quality_o
);
  import pfs_pkg::*;

  localparam int START_W = LVL_W + BLK_W + 1;

  logic [CNT_W-1:0]  items_count_q;
  logic [QUAL_W-1:0] max_quality_q;
  logic [BLK_W-1:0]  block_size_q;

  logic              mode_q;
  logic [ITEM_W-1:0] req_q;
  logic [ITEM_W-1:0] focus_q;
  logic              head_q;
  logic [LVL_W-1:0]  pass_q;
  logic [LVL_W-1:0]  level_q;
  logic [CNT_W-1:0]  pos_q;
  logic [CNT_W-1:0]  start_q;
  logic [CNT_W-1:0]  end_q;
  logic [QUAL_W-1:0] lo_q;
  logic [ITEM_W-1:0] rd_addr_q;
  logic [ITEMS_MAX-1:0] valid_q;

  logic              done_q;
  status_e           status_q;
  logic [ITEM_W-1:0] res_item_q;
  logic [QUAL_W-1:0] res_qual_q;

  logic [CNT_W-1:0]   n_eff;
  logic [BLK_W-1:0]   b_eff;
  logic [START_W-1:0] start_c;
  logic [START_W-1:0] sum_c;
  logic [CNT_W-1:0]   end_c;
  logic [QUAL_W-1:0]  lo_c;
  logic [LVL_W-1:0]   lvl_p;
  logic [CNT_W-1:0]   pos_p;
  logic [ITEM_W-1:0]  cand_item;
  logic [ITEM_W-1:0]  raddr;
  logic [LVL_W-1:0]   rdata;
  logic [LVL_W-1:0]   stored_lvl;
  logic               we;
  logic [LVL_W-1:0]   wdata;

  always_comb begin
    if (items_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (items_count_q > CNT_W'(ITEMS_MAX)) begin
      n_eff = CNT_W'(ITEMS_MAX);
    end else begin
      n_eff = items_count_q;
    end
  end

  assign b_eff   = (block_size_q == '0) ? BLK_W'(1) : block_size_q;
  assign start_c = START_W'(pass_q) * START_W'(b_eff) + START_W'(1);
  assign sum_c   = start_c + START_W'(b_eff);
  assign end_c   = (pass_q == LVL_W'(max_quality_q) || sum_c > START_W'(n_eff))
                   ? n_eff : sum_c[CNT_W-1:0];
  assign lo_c    = (LVL_W'(max_quality_q) >= pass_q + LVL_W'(1))
                   ? QUAL_W'(LVL_W'(max_quality_q) - pass_q - LVL_W'(1)) : '0;

  assign lvl_p     = (level_q < LVL_W'(lo_q)) ? LVL_W'(lo_q) : level_q;
  assign pos_p     = (pos_q < start_q) ? start_q : pos_q;
  assign cand_item = item_at(pos_p, focus_q, n_eff);

  assign raddr      = cmd_i.rd_head ? focus_q : cand_item;
  assign stored_lvl = valid_q[rd_addr_q] ? rdata : '0;
  assign we         = cmd_i.wr_head | cmd_i.wr_cand;
  assign wdata      = cmd_i.wr_head ? LVL_W'(max_quality_q) + LVL_W'(1)
                                    : level_q + LVL_W'(1);

  pfs_ram #(
    .WIDTH(LVL_W),
    .DEPTH(ITEMS_MAX)
  ) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(rd_addr_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.req_oob      = {1'b0, req_q} >= n_eff;
    sts_o.focus_oob    = {1'b0, focus_q} >= n_eff;
    sts_o.head_pending = head_q;
    sts_o.head_ok      = stored_lvl <= LVL_W'(max_quality_q);
    sts_o.pass_over    = pass_q > LVL_W'(max_quality_q);
    sts_o.start_ge_n   = start_c >= START_W'(n_eff);
    sts_o.level_over   = lvl_p > LVL_W'(max_quality_q);
    sts_o.pos_end      = pos_p >= end_q;
    sts_o.cand_ok      = stored_lvl <= level_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_count_q <= CNT_W'(1);
      max_quality_q <= '0;
      block_size_q  <= BLK_W'(2);
      focus_q       <= '0;
      head_q        <= 1'b1;
      pass_q        <= '0;
      level_q       <= '0;
      pos_q         <= '0;
      valid_q       <= '0;
      done_q        <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ITEMS_COUNT: items_count_q <= cfg_data_i;
          CFG_MAX_QUALITY: max_quality_q <= cfg_data_i[QUAL_W-1:0];
          CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i[BLK_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.set_focus) begin
        focus_q <= req_q;
        head_q  <= 1'b1;
        pass_q  <= '0;
        level_q <= '0;
        pos_q   <= '0;
      end
      if (cmd_i.rd_head) begin
        head_q <= 1'b0;
      end
      if (cmd_i.pass_exhaust) begin
        pass_q  <= LVL_W'(max_quality_q) + LVL_W'(1);
        level_q <= '0;
        pos_q   <= '0;
      end
      if (cmd_i.pass_next) begin
        pass_q  <= pass_q + LVL_W'(1);
        level_q <= '0;
        pos_q   <= '0;
      end
      if (cmd_i.level_next) begin
        level_q <= lvl_p + LVL_W'(1);
        pos_q   <= start_q;
      end
      if (cmd_i.rd_cand) begin
        level_q <= lvl_p;
        pos_q   <= pos_p + CNT_W'(1);
      end
      if (we) begin
        valid_q[rd_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q <= mode_i;
      req_q  <= focus_item_i;
    end
    if (cmd_i.setup) begin
      start_q <= start_c[CNT_W-1:0];
      end_q   <= end_c;
      lo_q    <= lo_c;
    end
    if (cmd_i.rd_head || cmd_i.rd_cand) begin
      rd_addr_q <= raddr;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      if (cmd_i.emit_status != ST_FETCH) begin
        res_item_q <= '0;
        res_qual_q <= '0;
      end else if (cmd_i.wr_head) begin
        res_item_q <= focus_q;
        res_qual_q <= max_quality_q;
      end else begin
        res_item_q <= rd_addr_q;
        res_qual_q <= level_q[QUAL_W-1:0];
      end
    end
  end

  assign done_o    = done_q;
  assign status_o  = status_q;
  assign item_o    = res_item_q;
  assign quality_o = res_qual_q;

endmodule

>>> src/progressive_fetch_scheduler_core.sv
// Progressive fetch scheduler: picks the next item and quality level to fetch
// around a focus item, centre-out, with a per-item next-level table.
// Command channel: drive start with mode_i/focus_item_i; the beat is taken
// when start is high and busy is low. mode_i = 1 moves the focus (no result
// unless focus_item_i is out of range, which returns status 2); mode_i = 0
// requests the next fetch and always returns one result.
// Results appear for exactly one cycle with done_o high, on status_o, item_o
// and quality_o; the receiver cannot stall them.
// A focus move or an out-of-range focus ends at decode; a head fetch adds one
// head table read; a scan request adds its set-up, each candidate read, each
// level step and each pass step (plus a head read if the head is satisfied).
// Candidates are tested one at a time through the table's single read port,
// so a request that skips many satisfied items takes proportionally longer.
// Configuration: cfg_valid/cfg_ready write channel, index 0 items_count,
// 1 max_quality, 2 block_size; write only while busy is low.
// Reset clears the table (per-entry valid bits), sets focus 0 and restarts
// the sequence; registers return to items_count 1, max_quality 0,
// block_size 2.
module progressive_fetch_scheduler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode_i,
  input  logic [pfs_pkg::ITEM_W-1:0]     focus_item_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [pfs_pkg::ITEM_W-1:0]     item_o,
  output logic [pfs_pkg::QUAL_W-1:0]     quality_o
);
  import pfs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy_w;

  assign cfg_ready_o = 1'b1;
  assign busy = busy_w;

  pfs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start & ~busy_w),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_w)
  );

  pfs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .focus_item_i(focus_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .status_o    (status_o),
    .item_o      (item_o),
    .quality_o   (quality_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_FETCH) |-> (item_o == '0) && (quality_o == '0))
    else $error("nonzero payload on non-fetch result");

endmodule
